// ===== hdl/fastq_read_base_quality_packer_macros.svh =====
// Assertion helpers for the FASTQ packer blocks.
// Each check is sampled on the rising edge of clock and skipped while reset is high.
`ifndef FASTQ_READ_BASE_QUALITY_PACKER_MACROS_SVH
`define FASTQ_READ_BASE_QUALITY_PACKER_MACROS_SVH

// Same-cycle implication.
`define FQPK_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication.
`define FQPK_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== hdl/fqpk_pkg.sv =====
package fqpk_pkg;

   localparam int MAX_LEN     = 64;
   localparam int STORE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int LEN_W       = $clog2(MAX_LEN + 1);
   localparam int BASE_W      = 3;

   localparam logic [7:0] NEWLINE       = 8'd10;
   localparam logic [7:0] CHAR_UPPER_N  = 8'h4E;
   localparam logic [7:0] OFFSET_RESET  = 8'd33;
   localparam logic [BASE_W-1:0] OTHER_BASE = 3'd4;

   // Controller to datapath commands
   typedef struct packed {
      logic clr_record;
      logic wr_base;
      logic clr_qcount;
      logic wr_qual;
      logic start_emit;
      logic load_out;
   } fqpk_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_newline;
      logic emit_ok;
      logic pos_zero;
      logic out_free;
   } fqpk_status_type;

   function automatic logic [BASE_W-1:0] base_code(input logic [7:0] c);
      logic [BASE_W-1:0] code;
      case (c) inside
         8'h41, 8'h61: code = 3'd0;
         8'h43, 8'h63: code = 3'd1;
         8'h47, 8'h67: code = 3'd2;
         8'h54, 8'h74: code = 3'd3;
         default:      code = OTHER_BASE;
      endcase
      return code;
   endfunction

endpackage

// ===== hdl/fqpk_ram.sv =====
module fqpk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/fqpk_ctrl.sv =====
`include "fastq_read_base_quality_packer_macros.svh"

module fqpk_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  fqpk_pkg::fqpk_status_type status,
   output fqpk_pkg::fqpk_cmd_type    cmd
);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_SEQ,
      PH_PLUS,
      PH_QUAL
   } phase_type;

   typedef enum logic [1:0] {
      PARSE,
      READ,
      LOAD
   } state_type;

   phase_type phase_ff, phase_in;
   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != PARSE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      phase_in = phase_ff;
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         PARSE: begin
            if (accept) begin
               case (phase_ff)
                  PH_HEADER: begin
                     if (status.is_newline) begin
                        cmd.clr_record = 1'b1;
                        phase_in       = PH_SEQ;
                     end
                  end
                  PH_SEQ: begin
                     if (status.is_newline) begin
                        phase_in = PH_PLUS;
                     end else begin
                        cmd.wr_base = 1'b1;
                     end
                  end
                  PH_PLUS: begin
                     if (status.is_newline) begin
                        cmd.clr_qcount = 1'b1;
                        phase_in       = PH_QUAL;
                     end
                  end
                  PH_QUAL: begin
                     if (status.is_newline) begin
                        phase_in = PH_HEADER;
                        if (status.emit_ok) begin
                           cmd.start_emit = 1'b1;
                           state_in       = READ;
                        end
                     end else begin
                        cmd.wr_qual = 1'b1;
                     end
                  end
                  default: phase_in = PH_HEADER;
               endcase
            end
         end
         READ: state_in = LOAD;
         LOAD: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               if (status.pos_zero) begin
                  state_in = PARSE;
               end
            end
         end
         default: state_in = PARSE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         state_ff <= PARSE;
      end else begin
         phase_ff <= phase_in;
         state_ff <= state_in;
      end
   end

   // never overwrite a result that is still waiting
   `FQPK_ASSERT_NOW(a_load_only_when_free, cmd.load_out, status.out_free)
   `FQPK_ASSERT_NEXT(a_read_then_load, state_ff == READ, state_ff == LOAD)
   `FQPK_ASSERT_NEXT(a_last_back_to_parse, cmd.load_out && status.pos_zero, state_ff == PARSE)

endmodule

// ===== hdl/fqpk_dp.sv =====
module fqpk_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [7:0]                req_stream_byte,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [7:0]                csr_quality_offset,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_packed_value,
   output logic [5:0]                rsp_base_position,
   output logic                      rsp_last_of_read,
   input  fqpk_pkg::fqpk_cmd_type    cmd,
   output fqpk_pkg::fqpk_status_type status
);

   logic [7:0]                       offset_ff;
   logic [fqpk_pkg::LEN_W-1:0]       read_length_ff;
   logic [fqpk_pkg::LEN_W-1:0]       quality_count_ff;
   logic                             saw_n_ff;
   logic [fqpk_pkg::ADDR_W-1:0]      pos_ff;
   logic [5:0]                       k_ff;
   logic                             rsp_valid_ff;
   logic [7:0]                       rsp_packed_ff;
   logic [5:0]                       rsp_position_ff;
   logic                             rsp_last_ff;

   logic                             base_room, qual_room;
   logic                             base_wr_en, qual_wr_en;
   logic [fqpk_pkg::ADDR_W-1:0]      rd_addr;
   logic [fqpk_pkg::BASE_W-1:0]      base_rd;
   logic [7:0]                       qual_rd;
   logic [7:0]                       qual_diff;
   logic [5:0]                       qual_field;
   logic [7:0]                       packed_value;

   assign csr_ready = 1'b1;

   assign base_room  = read_length_ff < fqpk_pkg::LEN_W'(fqpk_pkg::MAX_LEN);
   assign qual_room  = quality_count_ff < fqpk_pkg::LEN_W'(fqpk_pkg::MAX_LEN);
   assign base_wr_en = cmd.wr_base && base_room;
   assign qual_wr_en = cmd.wr_qual && qual_room;

   // read one ahead while results flow
   assign rd_addr = cmd.load_out ? pos_ff - 1'b1 : pos_ff;

   fqpk_ram #(
      .WIDTH(fqpk_pkg::BASE_W),
      .DEPTH(fqpk_pkg::STORE_DEPTH)
   ) u_base_ram (
      .clock  (clock),
      .wr_en  (base_wr_en),
      .wr_addr(read_length_ff[fqpk_pkg::ADDR_W-1:0]),
      .wr_data(fqpk_pkg::base_code(req_stream_byte)),
      .rd_addr(rd_addr),
      .rd_data(base_rd)
   );

   fqpk_ram #(
      .WIDTH(8),
      .DEPTH(fqpk_pkg::STORE_DEPTH)
   ) u_qual_ram (
      .clock  (clock),
      .wr_en  (qual_wr_en),
      .wr_addr(quality_count_ff[fqpk_pkg::ADDR_W-1:0]),
      .wr_data(req_stream_byte),
      .rd_addr(rd_addr),
      .rd_data(qual_rd)
   );

   // missing quality entries read as zero field
   assign qual_diff  = qual_rd - offset_ff;
   assign qual_field = ({1'b0, pos_ff} < quality_count_ff) ? qual_diff[5:0] : 6'd0;
   assign packed_value = (base_rd == fqpk_pkg::OTHER_BASE) || base_rd[2] ? 8'd0
                       : {qual_field, base_rd[1:0]};

   assign status.is_newline = (req_stream_byte == fqpk_pkg::NEWLINE);
   assign status.emit_ok    = (read_length_ff != '0) && !saw_n_ff;
   assign status.pos_zero   = (pos_ff == '0);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff        <= fqpk_pkg::OFFSET_RESET;
         read_length_ff   <= '0;
         quality_count_ff <= '0;
         saw_n_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            offset_ff <= csr_quality_offset;
         end
         if (cmd.clr_record) begin
            read_length_ff   <= '0;
            quality_count_ff <= '0;
            saw_n_ff         <= 1'b0;
         end
         if (cmd.wr_base) begin
            if (req_stream_byte == fqpk_pkg::CHAR_UPPER_N) begin
               saw_n_ff <= 1'b1;
            end
            if (base_room) begin
               read_length_ff <= read_length_ff + 1'b1;
            end
         end
         if (cmd.clr_qcount) begin
            quality_count_ff <= '0;
         end
         if (qual_wr_en) begin
            quality_count_ff <= quality_count_ff + 1'b1;
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // emission counters and result payload
   always_ff @(posedge clock) begin
      if (cmd.start_emit) begin
         pos_ff <= fqpk_pkg::ADDR_W'(read_length_ff - 1'b1);
         k_ff   <= '0;
      end else if (cmd.load_out) begin
         pos_ff <= pos_ff - 1'b1;
         k_ff   <= k_ff + 1'b1;
      end
      if (cmd.load_out) begin
         rsp_packed_ff   <= packed_value;
         rsp_position_ff <= k_ff;
         rsp_last_ff     <= (pos_ff == '0);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_packed_value  = rsp_packed_ff;
   assign rsp_base_position = rsp_position_ff;
   assign rsp_last_of_read  = rsp_last_ff;

endmodule

// ===== hdl/fastq_read_base_quality_packer.sv =====
// A kept read's first result is registered from LOAD, after its quality-line newline is taken
// and READ has passed; then one result per cycle while rsp_stall is low.
// Throughput: one byte per cycle, except that input stalls while a kept record is emitted
// (READ for the store read, then LOAD for each emitted base, which also waits on rsp_stall).
// Reset: synchronous, active high; clears line phase, length and quality counters, result valid, offset to 33.
// Base and quality stores are not cleared: only entries written for the current record are read.
module fastq_read_base_quality_packer (
   input  logic       clock,
   input  logic       reset,
   // request channel: FASTQ text, one byte per request
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_stream_byte,
   // result channel: one packed base per result, last base first
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_packed_value,
   output logic [5:0] rsp_base_position,
   output logic       rsp_last_of_read,
   // quality offset register
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_quality_offset
);

   // Controller follows the four-line record structure and steps the reversed
   // emission; the datapath holds the stores, counters and the result register.
   fqpk_pkg::fqpk_cmd_type    cmd;
   fqpk_pkg::fqpk_status_type status;

   fqpk_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   // The result register decouples the sides: once the last base is loaded the
   // controller returns to parsing while that result may still be waiting.
   fqpk_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_stream_byte   (req_stream_byte),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_quality_offset(csr_quality_offset),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_packed_value  (rsp_packed_value),
      .rsp_base_position (rsp_base_position),
      .rsp_last_of_read  (rsp_last_of_read),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   // ---------------------------------------------------------------- types

   // one packed base as it leaves the block
   typedef struct packed {
      logic [7:0] packed_value;
      logic [5:0] base_position;
      logic       last_of_read;
   } packed_base_type;

   typedef enum logic [1:0] {
      LINE_HEADER,
      LINE_BASES,
      LINE_PLUS,
      LINE_QUALITY
   } line_phase_type;

   // what the sender does next: a text byte, an offset write, or a control marker
   typedef enum {
      ITEM_BYTE,
      ITEM_CSR,
      ITEM_HOLD,     // ask the receiver for a long hold-off
      ITEM_DRAIN,    // wait until every expected base has come
      ITEM_SETTLE    // quiet cycles after a drain
   } item_kind_type;

   typedef struct {
      item_kind_type kind;
      logic [7:0]    value;
      int            gap;
   } text_item_type;

   typedef logic [7:0] chars_type[$];

   // ---------------------------------------------------------------- constants

   localparam logic [7:0] CH_A  = "A";
   localparam logic [7:0] CH_C  = "C";
   localparam logic [7:0] CH_G  = "G";
   localparam logic [7:0] CH_T  = "T";
   localparam logic [7:0] CH_LA = "a";
   localparam logic [7:0] CH_LC = "c";
   localparam logic [7:0] CH_LG = "g";
   localparam logic [7:0] CH_LT = "t";
   localparam logic [7:0] CH_AT = "@";

   localparam logic [2:0] CODE_A = 3'd0;
   localparam logic [2:0] CODE_C = 3'd1;
   localparam logic [2:0] CODE_G = 3'd2;
   localparam logic [2:0] CODE_T = 3'd3;

   localparam int MAX_GAP        = 14;
   localparam int HOLD_CYCLES    = 300;   // long receiver hold-off, fills the block
   localparam int SETTLE_CYCLES  = 8;     // emission starts after the newline, through READ then LOAD
   localparam int END_SETTLE     = 20;
   localparam int WATCHDOG_LIMIT = 3000;  // several times the longest legal silence
   localparam int MAX_REPORTS    = 10;
   localparam int TARGET_BYTES   = 210;

   // ---------------------------------------------------------------- ports

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_stream_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_packed_value;
   logic [5:0] rsp_base_position;
   logic       rsp_last_of_read;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_quality_offset = 8'd0;

   fastq_read_base_quality_packer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_stream_byte    (req_stream_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_packed_value   (rsp_packed_value),
      .rsp_base_position  (rsp_base_position),
      .rsp_last_of_read   (rsp_last_of_read),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_quality_offset (csr_quality_offset)
   );

   // ---------------------------------------------------------------- clock and reset

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // synchronous reset, released on a falling edge
   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------- shared state

   text_item_type   text_q[$];          // pending sender work, filled up front
   packed_base_type expected_bases_q[$];

   // handshake seen at the last rising edge, used by the falling-edge drivers
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic csr_fire = 1'b0;

   logic hold_req = 1'b0;            // toggled by the sender, noticed by the receiver
   int   quiet_cycles = 0;

   // sender
   text_item_type cur_item;
   bit            have_cur = 1'b0;

   // stimulus planning
   bit tx_quiet = 1'b0;
   int gen_newlines = 0;
   int planned_bytes = 0;
   int planned_records = 0;

   // scoreboard counters
   int mismatches = 0;
   int text_bytes = 0;
   int bases_checked = 0;
   int reads_checked = 0;
   int offset_writes = 0;

   // ---------------------------------------------------------------- packer prediction

   line_phase_type line_phase_now;
   logic [2:0]     base_mem[fqpk_pkg::MAX_LEN];
   logic [7:0]     qual_mem[fqpk_pkg::MAX_LEN];
   logic [6:0]     read_len;
   logic [6:0]     qual_cnt;
   logic           saw_upper_n;
   logic [7:0]     offset_now;

   function automatic logic [2:0] code_of_base(input logic [7:0] c);
      logic [2:0] code;
      if (c == CH_A || c == CH_LA)
         code = CODE_A;
      else if (c == CH_C || c == CH_LC)
         code = CODE_C;
      else if (c == CH_G || c == CH_LG)
         code = CODE_G;
      else if (c == CH_T || c == CH_LT)
         code = CODE_T;
      else
         code = fqpk_pkg::OTHER_BASE;
      return code;
   endfunction

   // advance the line parser by one text byte; a closing quality line
   // queues the read last base first
   task automatic take_text_byte(input logic [7:0] c);
      packed_base_type want;
      logic [7:0]      diff;
      logic [5:0]      qfield;
      int              pos;
      case (line_phase_now)
         LINE_HEADER: begin
            if (c == fqpk_pkg::NEWLINE) begin
               read_len       = '0;
               qual_cnt       = '0;
               saw_upper_n    = 1'b0;
               line_phase_now = LINE_BASES;
            end
         end
         LINE_BASES: begin
            if (c == fqpk_pkg::NEWLINE) begin
               line_phase_now = LINE_PLUS;
            end else begin
               if (c == fqpk_pkg::CHAR_UPPER_N)
                  saw_upper_n = 1'b1;
               // bases past the store are dropped, the length saturates
               if (read_len < fqpk_pkg::MAX_LEN) begin
                  base_mem[read_len[5:0]] = code_of_base(c);
                  read_len                = read_len + 1'b1;
               end
            end
         end
         LINE_PLUS: begin
            if (c == fqpk_pkg::NEWLINE) begin
               qual_cnt       = '0;
               line_phase_now = LINE_QUALITY;
            end
         end
         default: begin
            if (c == fqpk_pkg::NEWLINE) begin
               if (!saw_upper_n) begin
                  for (int k = 0; k < int'(read_len); k++) begin
                     pos  = int'(read_len) - 1 - k;
                     diff = qual_mem[pos[5:0]] - offset_now;
                     // short quality line: missing entries give field zero
                     qfield = (pos < int'(qual_cnt)) ? diff[5:0] : 6'd0;
                     if (base_mem[pos[5:0]] == fqpk_pkg::OTHER_BASE)
                        want.packed_value = 8'd0;
                     else
                        want.packed_value = {qfield, base_mem[pos[5:0]][1:0]};
                     want.base_position = k[5:0];
                     want.last_of_read  = (k + 1 == int'(read_len));
                     expected_bases_q = {expected_bases_q, want};
                  end
               end
               line_phase_now = LINE_HEADER;
            end else if (qual_cnt < fqpk_pkg::MAX_LEN) begin
               qual_mem[qual_cnt[5:0]] = c;
               qual_cnt                = qual_cnt + 1'b1;
            end
         end
      endcase
   endtask

   task automatic flag_mismatch(input string why, input packed_base_type want,
                                input packed_base_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t: %s: expected value %02h pos %0d last %0b, %s %02h pos %0d last %0b",
                  $time, why, want.packed_value, want.base_position, want.last_of_read,
                  "got value", got.packed_value, got.base_position, got.last_of_read);
   endtask

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : watch_ports
      packed_base_type got;
      packed_base_type want;
      if (reset) begin
         req_fire       <= 1'b0;
         rsp_fire       <= 1'b0;
         csr_fire       <= 1'b0;
         quiet_cycles   <= 0;
         line_phase_now = LINE_HEADER;
         read_len       = '0;
         qual_cnt       = '0;
         saw_upper_n    = 1'b0;
         offset_now     = fqpk_pkg::OFFSET_RESET;
      end else begin
         req_fire <= req_valid && !req_stall;
         rsp_fire <= rsp_valid && !rsp_stall;
         csr_fire <= csr_valid && csr_ready;

         // the user must make offset writes land only while the block is idle; the block does not enforce it
         if (csr_valid && csr_ready) begin
            offset_now = csr_quality_offset;
            offset_writes++;
         end

         // results first: a base can never stem from a request taken this edge
         if (rsp_valid && !rsp_stall) begin
            got.packed_value  = rsp_packed_value;
            got.base_position = rsp_base_position;
            got.last_of_read  = rsp_last_of_read;
            if (expected_bases_q.size() == 0) begin
               flag_mismatch("unexpected base", '0, got);
            end else begin
               want = expected_bases_q.pop_front();
               if (got.packed_value != want.packed_value)
                  flag_mismatch("packed_value", want, got);
               else if (got.base_position != want.base_position)
                  flag_mismatch("base_position", want, got);
               else if (got.last_of_read != want.last_of_read)
                  flag_mismatch("last_of_read", want, got);
               bases_checked++;
               if (want.last_of_read)
                  reads_checked++;
            end
         end

         if (req_valid && !req_stall) begin
            take_text_byte(req_stream_byte);
            text_bytes++;
         end

         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // nothing accepted for far too long
   always @(posedge clock) begin : watchdog
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d bases still expected",
                  $time, quiet_cycles, expected_bases_q.size());
         $display("fastq_read_base_quality_packer: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sender

   // one decision per falling edge, so each port gets one assignment per step
   always @(negedge clock) begin : drive_text
      logic       nxt_req_valid;
      logic [7:0] nxt_byte;
      logic       nxt_csr_valid;
      logic [7:0] nxt_offset;
      nxt_req_valid = req_valid;
      nxt_byte      = req_stream_byte;
      nxt_csr_valid = csr_valid;
      nxt_offset    = csr_quality_offset;
      if (reset) begin
         nxt_req_valid = 1'b0;
         nxt_csr_valid = 1'b0;
      end else begin
         if (req_valid && req_fire)
            nxt_req_valid = 1'b0;
         if (csr_valid && csr_fire)
            nxt_csr_valid = 1'b0;
         if (!nxt_req_valid && !nxt_csr_valid) begin
            if (!have_cur && text_q.size() != 0) begin
               cur_item = text_q.pop_front();
               have_cur = 1'b1;
            end
            if (have_cur) begin
               if (cur_item.gap != 0) begin
                  cur_item.gap--;
               end else begin
                  case (cur_item.kind)
                     ITEM_BYTE: begin
                        nxt_req_valid = 1'b1;
                        nxt_byte      = cur_item.value;
                        have_cur      = 1'b0;
                     end
                     ITEM_CSR: begin
                        nxt_csr_valid = 1'b1;
                        nxt_offset    = cur_item.value;
                        have_cur      = 1'b0;
                     end
                     ITEM_HOLD: begin
                        hold_req <= ~hold_req;
                        have_cur = 1'b0;
                     end
                     ITEM_DRAIN: begin
                        // sender pauses until the last queued base is out
                        if (expected_bases_q.size() == 0) begin
                           cur_item.kind = ITEM_SETTLE;
                           cur_item.gap  = SETTLE_CYCLES;
                        end
                     end
                     default: begin
                        have_cur = 1'b0;
                     end
                  endcase
               end
            end
         end
      end
      req_valid          <= nxt_req_valid;
      req_stream_byte    <= nxt_byte;
      csr_valid          <= nxt_csr_valid;
      csr_quality_offset <= nxt_offset;
   end

   // ---------------------------------------------------------------- receiver

   bit rx_quiet   = 1'b0;
   bit hold_seen  = 1'b0;
   int burst_left = 0;
   int hold_left  = 0;
   int wait_left  = 0;

   // draws a wait per result; bursts of zero waits are mixed at random with bursts of random ones
   always @(negedge clock) begin : drive_stall
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (rsp_fire) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(8, 40);
               rx_quiet   = ($urandom_range(0, 3) == 0);
            end
            burst_left--;
            wait_left = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (wait_left != 0) begin
            wait_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus helpers

   task automatic push_item(input item_kind_type kind, input logic [7:0] value);
      text_item_type it;
      it.kind  = kind;
      it.value = value;
      it.gap   = (kind == ITEM_BYTE && !tx_quiet) ? $urandom_range(0, MAX_GAP) : 0;
      text_q   = {text_q, it};
      if (kind == ITEM_BYTE) begin
         planned_bytes++;
         if (value == fqpk_pkg::NEWLINE)
            gen_newlines++;
      end
   endtask

   task automatic push_line(input chars_type chars);
      foreach (chars[i])
         push_item(ITEM_BYTE, chars[i]);
      push_item(ITEM_BYTE, fqpk_pkg::NEWLINE);
   endtask

   function automatic chars_type text(input string s);
      chars_type q;
      for (int i = 0; i < s.len(); i++)
         q = {q, s[i]};
      return q;
   endfunction

   function automatic logic [7:0] rand_text_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == fqpk_pkg::NEWLINE);
      return b;
   endfunction

   function automatic chars_type random_bases(input int n);
      chars_type  q;
      logic [7:0] alphabet[8] = '{CH_A, CH_C, CH_G, CH_T, CH_LA, CH_LC, CH_LG, CH_LT};
      for (int i = 0; i < n; i++)
         q = {q, alphabet[$urandom_range(0, 7)]};
      return q;
   endfunction

   // mostly printable Phred characters, some arbitrary bytes
   function automatic chars_type random_quals(input int n);
      chars_type q;
      for (int i = 0; i < n; i++)
         q = {q, (($urandom_range(0, 3) == 0) ? rand_text_byte()
                                              : 8'($urandom_range(33, 110)))};
      return q;
   endfunction

   // header and plus lines carry random bytes of their own
   task automatic push_record(input chars_type seq, input chars_type qual);
      chars_type header;
      chars_type plus;
      header = {header, CH_AT};
      repeat ($urandom_range(0, 2))
         header = {header, rand_text_byte()};
      plus = text("+");
      repeat ($urandom_range(0, 1))
         plus = {plus, rand_text_byte()};
      push_line(header);
      push_line(seq);
      push_line(plus);
      push_line(qual);
      planned_records++;
   endtask

   task automatic push_random_record();
      chars_type seq;
      chars_type qual;
      int        len;
      int        qlen;
      bit        has_n;
      tx_quiet = ($urandom_range(0, 3) == 0);
      len = $urandom_range(0, 8);
      seq = random_bases(len);
      foreach (seq[i])
         if ($urandom_range(0, 15) == 0)
            seq[i] = rand_text_byte();
      has_n = (len != 0) && ($urandom_range(0, 7) == 0);
      if (has_n)
         seq[$urandom_range(0, len - 1)] = fqpk_pkg::CHAR_UPPER_N;
      qlen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len + 6) : len;
      qual = random_quals(qlen);
      push_record(seq, qual);
   endtask

   // arbitrary bytes with stray newlines, then newlines to get back in step
   task automatic push_noise();
      tx_quiet = 1'b0;
      repeat ($urandom_range(3, 8))
         push_item(ITEM_BYTE, ($urandom_range(0, 5) == 0) ? fqpk_pkg::NEWLINE
                                                          : 8'($urandom_range(0, 255)));
      while (gen_newlines % 4 != 0)
         push_item(ITEM_BYTE, fqpk_pkg::NEWLINE);
   endtask

   // ---------------------------------------------------------------- test sequence

   initial begin : run_test
      chars_type qual;

      // directed records, offset still at its reset value
      tx_quiet = 1'b0;
      // all eight base letters, other characters, lowercase n and a carriage
      // return; quality extremes and wrap below the offset
      qual = {8'h00, 8'hFF, 8'h21, 8'h20, 8'h60, 8'h5F, 8'h7F, 8'h80, 8'h49, 8'h49, 8'h49};
      push_record(text("ACGTacgtnX\r"), qual);
      // uppercase N drops the record
      push_record(text("CN"), text("II"));
      // empty sequence line
      push_record(text(""), text("I"));

      // long read under offset 255: bases and quality both past the store
      push_item(ITEM_DRAIN, 8'd0);
      push_item(ITEM_CSR, 8'd255);
      tx_quiet = 1'b1;
      push_record(random_bases(fqpk_pkg::MAX_LEN + 1), random_quals(fqpk_pkg::MAX_LEN + 1));
      // receiver holds off while the next record keeps coming; short quality line
      push_item(ITEM_HOLD, 8'd0);
      push_record(text("ACG"), text("5"));

      // offset 0, stray bytes and random records
      push_item(ITEM_DRAIN, 8'd0);
      push_item(ITEM_CSR, 8'd0);
      push_noise();
      while (planned_bytes < TARGET_BYTES)
         push_random_record();

      // everything sent and every base back
      do
         @(posedge clock);
      while (reset || text_q.size() != 0 || have_cur || req_valid || csr_valid
             || expected_bases_q.size() != 0);
      repeat (END_SETTLE) @(posedge clock);

      if (expected_bases_q.size() != 0) begin
         $display("%0d expected bases never arrived", expected_bases_q.size());
         mismatches += expected_bases_q.size();
      end

      $display("covered %0d text bytes over %0d records, %0d reads and %0d bases checked",
               text_bytes, planned_records, reads_checked, bases_checked);
      $display("%0d offset writes incl. 0 and 255, one long receiver hold, %0d mismatches",
               offset_writes, mismatches);
      if (mismatches == 0)
         $display("fastq_read_base_quality_packer: match");
      else
         $display("fastq_read_base_quality_packer: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/fqpk_pkg.sv
hdl/fqpk_ram.sv
hdl/fqpk_ctrl.sv
hdl/fqpk_dp.sv
hdl/fastq_read_base_quality_packer.sv
verif/tb_top.sv
